FILE: sv/cst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// shared types for the counting semaphore table: beats, status codes and
// the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package cst_pkg;

  // request kinds
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_WAIT   = 2'd1;
  localparam logic [1:0] REQ_SIGNAL = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ID      = 3'd1,
    ST_NO_SLOT     = 3'd2,
    ST_NOT_CREATED = 3'd3,
    ST_TIMEOUT     = 3'd4,
    ST_OVERFLOW    = 3'd5,
    ST_BLOCKED     = 3'd6,
    ST_WAIT_FULL   = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  sem_id;
    logic [15:0] unit_count;
    logic [15:0] max_count;
    logic [7:0]  task_id;
    logic        poll_only;
  } req_beat_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  created_id;
    logic        released_valid;
    logic [7:0]  released_task;
    logic        last;
  } rsp_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic    idle;         // input side may take a beat
    logic    latch;        // capture the request beat
    logic    create;       // load the next free slot
    logic    take;         // subtract units from the slot count
    logic    queue;        // append a waiter entry
    logic    sig_start;    // begin a release walk with count plus units
    logic    release_one;  // drop the current waiter, charge its need
    logic    keep;         // copy the current waiter down
    logic    brk_set;      // stop releasing for the rest of the walk
    logic    adv;          // step to the next waiter entry
    logic    fin;          // write back the count, shrink the waiter list
    logic    emit;         // load the output register
    status_t res_status;
    logic    res_created;
    logic    res_released;
    logic    res_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic is_create;
    logic is_wait;
    logic bad_id;
    logic created;
    logic slot_free;
    logic cnt_ge;
    logic poll;
    logic wfull;
    logic wempty;
    logic ovf;
    logic match;
    logic can;
    logic walk_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/cst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/cst_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_dpath
// request registers, slot and waiter memories, counters and output register
// ----------------------------------------------------------------------------
module cst_dpath #(
  parameter int SEM_SLOTS  = 16,
  parameter int WAIT_SLOTS = 8,
  parameter int COUNT_BITS = 16,
  parameter int TASK_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire cst_pkg::req_beat_t req,
  output cst_pkg::rsp_beat_t      rsp,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  input  wire cst_pkg::cmd_t      cmd,
  output cst_pkg::sts_t           sts
);
  import cst_pkg::*;

  localparam int CB  = COUNT_BITS;
  localparam int TB  = TASK_BITS;
  localparam int SB  = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int SCW = $clog2(SEM_SLOTS + 1);
  localparam int WB  = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int WCW = $clog2(WAIT_SLOTS + 1);
  localparam int EW  = SB + TB + CB;

  // request registers
  logic [1:0]    req_type;
  logic          bad;
  logic [SB-1:0] sid;
  logic [CB-1:0] units;
  logic [CB-1:0] max_in;
  logic [TB-1:0] task_r;
  logic          poll;

  // counters and walk state
  logic [SCW-1:0] fill;
  logic [WCW-1:0] wfill;
  logic [WCW-1:0] ri;
  logic [WCW-1:0] wi;
  logic           brk;
  logic [CB-1:0]  cnt;
  logic [CB-1:0]  mx;

  // memories
  logic              s_we;
  logic [SB-1:0]     s_waddr;
  logic [2*CB-1:0]   s_wdata;
  logic [2*CB-1:0]   s_rdata;
  logic              w_we;
  logic [WB-1:0]     w_waddr;
  logic [EW-1:0]     w_wdata;
  logic [EW-1:0]     w_rdata;

  logic [CB-1:0] rd_cnt;
  logic [CB-1:0] rd_max;
  logic [CB-1:0] e_need;
  logic [TB-1:0] e_task;
  logic [SB-1:0] e_slot;
  logic [CB:0]   sum;
  logic          out_free;
  rsp_beat_t     res;

  assign rd_cnt = s_rdata[CB-1:0];
  assign rd_max = s_rdata[CB +: CB];
  assign e_need = w_rdata[CB-1:0];
  assign e_task = w_rdata[CB +: TB];
  assign e_slot = w_rdata[CB+TB +: SB];
  assign sum    = {1'b0, rd_cnt} + {1'b0, units};
  assign out_free = !rsp_valid || !rsp_stall;

  cst_ram #(.WIDTH(2*CB), .DEPTH(SEM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (sid),
    .rdata (s_rdata)
  );

  cst_ram #(.WIDTH(EW), .DEPTH(WAIT_SLOTS)) u_wait_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (ri[WB-1:0]),
    .rdata (w_rdata)
  );

  always_comb begin
    s_we    = cmd.create || cmd.take || cmd.fin;
    s_waddr = sid;
    s_wdata = {mx, cnt};
    if (cmd.create) begin
      s_waddr = fill[SB-1:0];
      s_wdata = {max_in, units};
    end else if (cmd.take) begin
      s_wdata = {rd_max, rd_cnt - units};
    end
  end

  always_comb begin
    w_we    = cmd.queue || cmd.keep;
    w_waddr = wi[WB-1:0];
    w_wdata = w_rdata;
    if (cmd.queue) begin
      w_waddr = wfill[WB-1:0];
      w_wdata = {sid, task_r, units};
    end
  end

  always_comb begin
    sts.in_valid  = req_valid;
    sts.is_create = (req_type == REQ_CREATE);
    sts.is_wait   = (req_type == REQ_WAIT);
    sts.bad_id    = bad;
    sts.created   = (SCW'(sid) < fill);
    sts.slot_free = (fill < SCW'(SEM_SLOTS));
    sts.cnt_ge    = (rd_cnt >= units);
    sts.poll      = poll;
    sts.wfull     = (wfill == WCW'(WAIT_SLOTS));
    sts.wempty    = (wfill == '0);
    sts.ovf       = (sum > {1'b0, rd_max});
    sts.match     = !brk && (e_slot == sid);
    sts.can       = (cnt >= e_need);
    sts.walk_end  = ((ri + WCW'(1)) == wfill);
    sts.out_free  = out_free;
  end

  always_comb begin
    res.status         = cmd.res_status;
    res.created_id     = cmd.res_created ? (8'(fill) + 8'd1) : 8'd0;
    res.released_valid = cmd.res_released;
    res.released_task  = cmd.res_released ? 8'(e_task) : 8'd0;
    res.last           = cmd.res_last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      wfill     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.create) begin
        fill <= fill + SCW'(1);
      end
      if (cmd.queue) begin
        wfill <= wfill + WCW'(1);
      end else if (cmd.fin) begin
        wfill <= wi;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type <= req.req_type;
      bad      <= (req.req_type == 2'd3) || (req.sem_id == 8'd0) ||
                  (req.sem_id > 8'(SEM_SLOTS));
      sid      <= SB'(req.sem_id - 8'd1);
      units    <= CB'(req.unit_count);
      max_in   <= CB'(req.max_count);
      task_r   <= TB'(req.task_id);
      poll     <= req.poll_only;
    end
    if (cmd.sig_start) begin
      cnt <= sum[CB-1:0];
      mx  <= rd_max;
      ri  <= '0;
      wi  <= '0;
      brk <= 1'b0;
    end else begin
      if (cmd.release_one) begin
        cnt <= cnt - e_need;
      end
      if (cmd.keep) begin
        wi <= wi + WCW'(1);
      end
      if (cmd.brk_set) begin
        brk <= 1'b1;
      end
      if (cmd.adv) begin
        ri <= ri + WCW'(1);
      end
    end
    if (cmd.emit) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

FILE: sv/cst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_ctrl
// request sequencer: decode, slot access, waiter walk and result issue
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cst_pkg::sts_t sts,
  output cst_pkg::cmd_t      cmd
);
  import cst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EXEC,
    S_WREAD,
    S_WCHK,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.is_create) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.res_last = 1'b1;
            if (sts.slot_free) begin
              cmd.create      = 1'b1;
              cmd.res_created = 1'b1;
              cmd.res_status  = ST_OK;
            end else begin
              cmd.res_status = ST_NO_SLOT;
            end
            state_next = S_IDLE;
          end
        end else if (sts.bad_id) begin
          if (sts.out_free) begin
            cmd.emit       = 1'b1;
            cmd.res_last   = 1'b1;
            cmd.res_status = ST_BAD_ID;
            state_next     = S_IDLE;
          end
        end else if (!sts.created) begin
          if (sts.out_free) begin
            cmd.emit       = 1'b1;
            cmd.res_last   = 1'b1;
            cmd.res_status = ST_NOT_CREATED;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          if (sts.is_wait) begin
            cmd.emit     = 1'b1;
            cmd.res_last = 1'b1;
            state_next   = S_IDLE;
            priority if (sts.cnt_ge) begin
              cmd.take       = 1'b1;
              cmd.res_status = ST_OK;
            end else if (sts.poll) begin
              cmd.res_status = ST_TIMEOUT;
            end else if (sts.wfull) begin
              cmd.res_status = ST_WAIT_FULL;
            end else begin
              cmd.queue      = 1'b1;
              cmd.res_status = ST_BLOCKED;
            end
          end else if (sts.ovf) begin
            cmd.emit       = 1'b1;
            cmd.res_last   = 1'b1;
            cmd.res_status = ST_OVERFLOW;
            state_next     = S_IDLE;
          end else begin
            cmd.sig_start = 1'b1;
            state_next    = sts.wempty ? S_FIN : S_WREAD;
          end
        end
      end
      S_WREAD: begin
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (sts.match && sts.can) begin
          if (sts.out_free) begin
            cmd.emit         = 1'b1;
            cmd.release_one  = 1'b1;
            cmd.res_released = 1'b1;
            cmd.res_status   = ST_OK;
            cmd.adv          = 1'b1;
            state_next       = sts.walk_end ? S_FIN : S_WREAD;
          end
        end else begin
          cmd.keep    = 1'b1;
          cmd.brk_set = sts.match;
          cmd.adv     = 1'b1;
          state_next  = sts.walk_end ? S_FIN : S_WREAD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin        = 1'b1;
          cmd.emit       = 1'b1;
          cmd.res_last   = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/counting_semaphore_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_table
// table of counting semaphores serving create, wait and signal requests
// ----------------------------------------------------------------------------
// One request beat is taken at a time and answered with one result beat
// (create, wait, and a refused signal) or with one beat per released task
// followed by a final beat with last set (signal). The last result beat is
// loaded in the check state for create and rejected ids, in the execute
// state for wait and an overflowing signal, and in the finish state for
// any other signal after a walk of all queued waiters (up to WAIT_SLOTS);
// the sequencer then goes idle for the next request. The walk spends a
// read and a check state on each waiter entry, as the waiter memory has a
// registered read port, and every entry behind a release is copied down
// to keep arrival order. A response stall holds the sequencer in any state
// that must load a beat. Slots are never deleted, so the created slots
// always form a prefix and a fill count replaces both the per-slot exist
// bits and the free-slot search; the waiter list is likewise packed and
// tracked by a fill count, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
  parameter int SEM_SLOTS  = 16,
  parameter int WAIT_SLOTS = 8,
  parameter int COUNT_BITS = 16,
  parameter int TASK_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire cst_pkg::req_beat_t req,
  // response channel
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output cst_pkg::rsp_beat_t      rsp
);
  import cst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one request in flight at a time
  cst_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // slot and waiter storage, counters, output beat register
  cst_dpath #(
    .SEM_SLOTS  (SEM_SLOTS),
    .WAIT_SLOTS (WAIT_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .TASK_BITS  (TASK_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // the request side opens whenever the sequencer is idle, even while the
  // previous result beat still sits in the output register
  assign req_stall = !cmd.idle;

endmodule
`default_nettype wire
